// ===== design/wildcard_byte_pattern_search_unit_assert.svh =====
// assertion macros shared by the search unit
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_UNIT_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define WBPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wbps assertion failed");

// consequent checked in the cycle after the antecedent
`define WBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wbps assertion failed");

`endif

// ===== design/wbps_pkg.sv =====
package wbps_pkg;

    // defaults for the top level parameters
    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // pattern bytes held in the two pattern registers
    localparam int PATTERN_REG_BYTES = 16;

    // width of the reported offset
    localparam int RESULT_OFFSET_W = 32;

    typedef logic [7:0] t_byte;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW     = 3'd0,
        CFG_PATTERN_HIGH    = 3'd1,
        CFG_PATTERN_LENGTH  = 3'd2,
        CFG_WILDCARD_VALUE  = 3'd3,
        CFG_WILDCARD_ENABLE = 3'd4
    } t_cfg_idx;

    // controls broadcast to every cell of the window
    typedef struct packed {
        logic  adv;
        logic  clr;
        logic  wild;
        t_byte wc;
    } t_cell_ctrl;

endpackage

// ===== design/wbps_if.sv =====
// request channel: one buffer byte per request
interface wbps_in_if import wbps_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

// result channel: found flag and match offset
interface wbps_out_if import wbps_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       match_found;
    logic [RESULT_OFFSET_W-1:0] match_offset;

    modport source (output valid, output match_found, output match_offset, input ready);
    modport sink   (input valid, input match_found, input match_offset, output ready);
endinterface

// ===== design/wbps_cell.sv =====
module wbps_cell import wbps_pkg::*; #(
    parameter bit STORE = 1'b1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_byte      i_byte,
    input  t_byte      i_pat,
    input  logic       i_use,
    output t_byte      o_byte,
    output logic       o_ok
);

    logic w_pat_hit;

    // byte compare, wildcard pattern byte matches anything while i_ctrl.wild is set
    assign w_pat_hit = (i_byte == i_pat) || (i_ctrl.wild && (i_pat == i_ctrl.wc));
    assign o_ok      = !i_use || w_pat_hit;

    // window register, handed to the next older cell
    if (STORE) begin : g_store
        t_byte r_byte;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_byte <= '0;
            end else if (i_ctrl.clr) begin
                r_byte <= '0;
            end else if (i_ctrl.adv) begin
                r_byte <= i_byte;
            end
        end

        assign o_byte = r_byte;
    end else begin : g_tail
        assign o_byte = '0;
    end

endmodule

// ===== design/wildcard_byte_pattern_search_unit.sv =====
// a result is registered and valid in the cycle after the request carrying the matching or last byte
// throughput: 1 byte per cycle while the request side is ready, the whole window is compared in the cell row each cycle
// the request side stays ready while a result waits, as long as the result register frees
// reset: synchronous active low; pattern length returns to 1, other configuration registers to zero,
// window, byte count, done flag and result valid clear at once; the result payload is not reset
`include "wildcard_byte_pattern_search_unit_assert.svh"

module wildcard_byte_pattern_search_unit import wbps_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wbps_in_if.sink               i_req,
    wbps_out_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam int KW      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PAT_SRC = (MAX_PATTERN < PATTERN_REG_BYTES) ? MAX_PATTERN
                                                               : PATTERN_REG_BYTES;
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [63:0] r_pat_low;
    logic [63:0] r_pat_high;
    logic [4:0]  r_pat_len;
    t_byte       r_wc;
    logic        r_wc_en;

    // search state
    logic [OFFSET_BITS-1:0] r_bytes_seen;
    logic                   r_done;

    // result register
    logic                       r_out_valid;
    logic                       r_out_found;
    logic [RESULT_OFFSET_W-1:0] r_out_offset;

    logic [127:0]               w_pat_all;
    t_byte                      w_pat   [MAX_PATTERN];
    t_byte                      w_align [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]     w_use;
    logic [MAX_PATTERN-1:0]     w_ok;
    t_byte                      w_age   [MAX_PATTERN];
    logic [LEN_W-1:0]           w_len;
    logic [OFFSET_BITS-1:0]     w_lenm1;
    logic [OFFSET_BITS-1:0]     w_off;
    logic [RESULT_OFFSET_W-1:0] w_off_out;
    t_cell_ctrl                 w_ctrl;
    logic                       w_acc;
    logic                       w_hit;
    logic                       w_res_valid;

    // handshake
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;

    // effective pattern length, clamped to the window size
    always_comb begin
        if (int'(r_pat_len) > MAX_PATTERN) begin
            w_len = LEN_W'(MAX_PATTERN);
        end else begin
            w_len = LEN_W'(r_pat_len);
        end
    end

    // pattern bytes, those beyond the registers read as zero
    assign w_pat_all = {r_pat_high, r_pat_low};

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            w_pat[k] = '0;
        end
        for (int k = 0; k < PAT_SRC; k++) begin
            w_pat[k] = w_pat_all[8*k +: 8];
        end
    end

    // pattern byte seen by the cell of each age
    always_comb begin
        for (int a = 0; a < MAX_PATTERN; a++) begin
            w_use[a] = (LEN_W'(a) < w_len);
            if (w_use[a]) begin
                w_align[a] = w_pat[KW'(int'(w_len) - 1 - a)];
            end else begin
                w_align[a] = '0;
            end
        end
    end

    // cell controls
    assign w_ctrl.adv  = w_acc;
    assign w_ctrl.clr  = w_acc && i_req.buffer_end;
    assign w_ctrl.wild = r_wc_en && (r_pat_low[7:0] != r_wc);
    assign w_ctrl.wc   = r_wc;

    // row of window cells, newest byte enters at age zero
    assign w_age[0] = i_req.data_byte;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        if (j < MAX_PATTERN - 1) begin : g_mid
            wbps_cell #(
                .STORE (1'b1)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_byte  (w_age[j]),
                .i_pat   (w_align[j]),
                .i_use   (w_use[j]),
                .o_byte  (w_age[j+1]),
                .o_ok    (w_ok[j])
            );
        end else begin : g_last
            wbps_cell #(
                .STORE (1'b0)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_byte  (w_age[j]),
                .i_pat   (w_align[j]),
                .i_use   (w_use[j]),
                .o_byte  (),
                .o_ok    (w_ok[j])
            );
        end
    end

    // match decision and start offset
    assign w_lenm1 = OFFSET_BITS'(w_len) - OFFSET_BITS'(1);
    assign w_hit   = !r_done && (w_len != '0) && (r_bytes_seen >= w_lenm1) && (&w_ok);
    assign w_off   = (r_bytes_seen == COUNT_MAX) ? COUNT_MAX : (r_bytes_seen - w_lenm1);

    // offset saturated to the result width when wider, else zero-extended
    if (OFFSET_BITS > RESULT_OFFSET_W) begin : g_off_sat
        assign w_off_out = (|w_off[OFFSET_BITS-1:RESULT_OFFSET_W]) ? '1
                                                                    : w_off[RESULT_OFFSET_W-1:0];
    end else begin : g_off_ext
        assign w_off_out = RESULT_OFFSET_W'(w_off);
    end

    assign w_res_valid = w_acc && (w_hit || (i_req.buffer_end && !r_done));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= 5'd1;
            r_wc       <= '0;
            r_wc_en    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERN_LOW:     r_pat_low  <= i_cfg_data;
                CFG_PATTERN_HIGH:    r_pat_high <= i_cfg_data;
                CFG_PATTERN_LENGTH:  r_pat_len  <= i_cfg_data[4:0];
                CFG_WILDCARD_VALUE:  r_wc       <= i_cfg_data[7:0];
                CFG_WILDCARD_ENABLE: r_wc_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // byte count and done flag, cleared by the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_done       <= 1'b0;
        end else if (w_acc) begin
            if (i_req.buffer_end) begin
                r_bytes_seen <= '0;
                r_done       <= 1'b0;
            end else begin
                if (r_bytes_seen != COUNT_MAX) begin
                    r_bytes_seen <= r_bytes_seen + OFFSET_BITS'(1);
                end
                r_done <= r_done || w_hit;
            end
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_found  <= w_hit;
            r_out_offset <= w_hit ? w_off_out : '0;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.match_found  = r_out_found;
    assign o_rsp.match_offset = r_out_offset;

    // checks
    `WBPS_ASSERT_NOW(a_ready_when_empty, !r_out_valid, i_req.ready)
    `WBPS_ASSERT_NEXT(a_end_clears_state, w_acc && i_req.buffer_end, (r_bytes_seen == '0) && !r_done)
    `WBPS_ASSERT_NOW(a_notfound_zero_offset, r_out_valid && !r_out_found, r_out_offset == '0)
    `WBPS_ASSERT_NOW(a_done_silent, w_acc && r_done, !w_res_valid)

endmodule
